[rtl/plc_pkg.sv]
`default_nettype none

package plc_pkg;

    localparam int CACHE_LINES  = 8;
    localparam int LINE_RECORDS = 16;
    localparam int SLOT_W       = $clog2(CACHE_LINES);
    localparam int OFF_W        = $clog2(LINE_RECORDS);
    localparam int REC_W        = 24;
    localparam int LINE_W       = REC_W - OFF_W;
    localparam int NREC_W       = 25;
    localparam int CNT_W        = $clog2(LINE_RECORDS) + 1;
    localparam int STAMP_W      = 32;

    // request codes
    localparam logic [2:0] REQ_BEGIN_READ  = 3'd0;
    localparam logic [2:0] REQ_END_READ    = 3'd1;
    localparam logic [2:0] REQ_BEGIN_WRITE = 3'd2;
    localparam logic [2:0] REQ_END_WRITE   = 3'd3;
    localparam logic [2:0] REQ_PREFETCH    = 3'd4;
    localparam logic [2:0] REQ_FLUSH       = 3'd5;

    // result status codes
    localparam logic [2:0] STS_HIT       = 3'd0;
    localparam logic [2:0] STS_MISS      = 3'd1;
    localparam logic [2:0] STS_NO_FREE   = 3'd2;
    localparam logic [2:0] STS_READ_ONLY = 3'd3;
    localparam logic [2:0] STS_RANGE     = 3'd4;
    localparam logic [2:0] STS_DONE      = 3'd5;

    // line states
    localparam logic [1:0] LS_FREE  = 2'd0;
    localparam logic [1:0] LS_INUSE = 2'd1;
    localparam logic [1:0] LS_FETCH = 2'd2;

    // configuration register indexes
    localparam logic CFG_READ_ONLY   = 1'b0;
    localparam logic CFG_NUM_RECORDS = 1'b1;

    typedef logic [CACHE_LINES-1:0] t_line_vec;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [REC_W-1:0] record_index;
    } t_in_word;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [OFF_W-1:0]  line_offset;
        logic              writeback_valid;
        logic [LINE_W-1:0] writeback_line;
        logic [CNT_W-1:0]  writeback_count;
        logic              fill_valid;
        logic [LINE_W-1:0] fill_line;
        logic [CNT_W-1:0]  fill_count;
        logic              fill_prefetch;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic               valid;
        logic [1:0]         state;
        logic               dirty;
        logic [LINE_W-1:0]  tag;
        logic [STAMP_W-1:0] stamp;
    } t_line_entry;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        t_line_entry       entry;
    } t_line_wr;

    // records of a line that lie inside the backing store
    function automatic logic [CNT_W-1:0] crop_count(logic [LINE_W-1:0] line,
                                                    logic [NREC_W-1:0] num);
        logic [NREC_W-1:0] start;
        logic [NREC_W-1:0] left;
        start = {1'b0, line, {OFF_W{1'b0}}};
        left  = num - start;
        if (start >= num) begin
            return '0;
        end else if (left < NREC_W'(LINE_RECORDS)) begin
            return left[CNT_W-1:0];
        end else begin
            return CNT_W'(LINE_RECORDS);
        end
    endfunction

endpackage

`default_nettype wire

[rtl/plc_line_store.sv]
`default_nettype none

module plc_line_store
    import plc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [SLOT_W-1:0] i_rd_idx,
    output t_line_entry            o_entry,
    output t_line_vec              o_dirty_vec,
    input  wire t_line_wr          i_wr
);

    t_line_entry r_line [CACHE_LINES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CACHE_LINES; i++) begin
                r_line[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_line[i_wr.idx] <= i_wr.entry;
        end
    end

    assign o_entry = r_line[i_rd_idx];

    always_comb begin
        for (int i = 0; i < CACHE_LINES; i++) begin
            o_dirty_vec[i] = r_line[i].dirty;
        end
    end

endmodule

`default_nettype wire

[rtl/plc_out_reg.sv]
`default_nettype none

module plc_out_reg
    import plc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_word i_word,
    output logic           o_ready,
    output logic           o_valid,
    output t_out_word      o_word,
    input  wire logic      i_stall
);

    logic      r_valid;
    t_out_word r_word;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

[rtl/plc_seq.sv]
`default_nettype none

module plc_seq
    import plc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire t_in_word          i_in_word,
    output logic                   o_in_stall,
    input  wire logic              i_read_only,
    input  wire logic [NREC_W-1:0] i_num_records,
    input  wire t_line_entry       i_entry,
    input  wire t_line_vec         i_dirty_vec,
    output logic [SLOT_W-1:0]      o_rd_idx,
    output t_line_wr               o_wr,
    input  wire logic              i_out_ready,
    output logic                   o_push,
    output t_out_word              o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_COMMIT,
        S_FLUSH,
        S_EMIT
    } t_state;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(CACHE_LINES - 1);

    t_state             r_state;
    logic [2:0]         r_req;
    logic [REC_W-1:0]   r_rec;
    logic [SLOT_W-1:0]  r_idx;
    logic [STAMP_W-1:0] r_stamp;
    logic               r_hit;
    logic               r_vic_found;
    logic [SLOT_W-1:0]  r_vic_idx;
    logic [STAMP_W-1:0] r_vic_stamp;
    logic [LINE_W-1:0]  r_vic_tag;
    logic               r_vic_dirty;
    logic [CNT_W-1:0]   r_fill_cnt;
    t_out_word          r_res;

    t_out_word          n_res;
    logic               w_is_begin;
    logic               w_is_pre;
    logic [LINE_W-1:0]  w_line;
    logic [OFF_W-1:0]   w_off;
    logic               w_tag_eq;
    logic               w_older_free;
    logic               w_out_range;

    assign w_line     = r_rec[REC_W-1:OFF_W];
    assign w_off      = r_rec[OFF_W-1:0];
    assign w_is_pre   = (r_req == REQ_PREFETCH);
    assign w_is_begin = (r_req == REQ_BEGIN_READ) || (r_req == REQ_BEGIN_WRITE) || w_is_pre;
    assign w_out_range = {1'b0, r_rec} >= i_num_records;

    // shared scan comparator: tag match and older-free-line test
    assign w_tag_eq     = i_entry.valid && (i_entry.tag == w_line);
    assign w_older_free = (i_entry.state == LS_FREE) &&
                          (!r_vic_found || (i_entry.stamp < r_vic_stamp));

    assign o_rd_idx   = r_idx;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_push     = (r_state == S_EMIT) && i_out_ready;
    assign o_res      = r_res;

    // result word and store write for the current step
    always_comb begin
        n_res      = '0;
        n_res.line_offset = w_off;
        n_res.last = 1'b1;
        o_wr       = '0;
        o_wr.idx   = r_idx;
        o_wr.entry = i_entry;
        case (r_state)
            S_DECODE: begin
                if (r_req == REQ_FLUSH) begin
                    n_res.status      = STS_DONE;
                    n_res.line_offset = '0;
                end else if (w_is_begin && w_out_range &&
                             !(r_req == REQ_BEGIN_WRITE && i_read_only)) begin
                    n_res.status = STS_RANGE;
                end else begin
                    n_res.status = STS_READ_ONLY;
                end
            end
            S_COMMIT: begin
                if (r_hit) begin
                    o_wr.en     = 1'b1;
                    n_res.slot  = r_idx;
                    if (w_is_begin) begin
                        n_res.status       = STS_HIT;
                        o_wr.entry.state   = LS_INUSE;
                        o_wr.entry.stamp   = r_stamp;
                    end else begin
                        n_res.status       = STS_DONE;
                        o_wr.entry.state   = LS_FREE;
                        o_wr.entry.dirty   = i_entry.dirty || (r_req == REQ_END_WRITE);
                    end
                end else if (!w_is_begin) begin
                    n_res.status = STS_DONE;
                end else if (!r_vic_found) begin
                    n_res.status = STS_NO_FREE;
                end else begin
                    o_wr.en          = 1'b1;
                    o_wr.idx         = r_vic_idx;
                    o_wr.entry.valid = 1'b1;
                    o_wr.entry.state = w_is_pre ? LS_FETCH : LS_INUSE;
                    o_wr.entry.dirty = 1'b0;
                    o_wr.entry.tag   = w_line;
                    o_wr.entry.stamp = r_stamp;
                    n_res.status          = STS_MISS;
                    n_res.slot            = r_vic_idx;
                    n_res.writeback_valid = r_vic_dirty;
                    if (r_vic_dirty) begin
                        n_res.writeback_line  = r_vic_tag;
                        n_res.writeback_count = crop_count(r_vic_tag, i_num_records);
                    end
                    n_res.fill_valid    = 1'b1;
                    n_res.fill_line     = w_line;
                    n_res.fill_count    = r_fill_cnt;
                    n_res.fill_prefetch = w_is_pre;
                end
            end
            S_FLUSH: begin
                n_res.status          = STS_DONE;
                n_res.slot            = r_idx;
                n_res.line_offset     = '0;
                n_res.writeback_valid = 1'b1;
                n_res.writeback_line  = i_entry.tag;
                n_res.writeback_count = crop_count(i_entry.tag, i_num_records);
                n_res.last = ((i_dirty_vec & ~(t_line_vec'(1) << r_idx)) == '0);
                o_wr.en          = i_entry.dirty;
                o_wr.entry.dirty = 1'b0;
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stamp     <= '0;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_vic_found <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_word.req_type;
                        r_rec   <= i_in_word.record_index;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_idx       <= '0;
                    r_hit       <= 1'b0;
                    r_vic_found <= 1'b0;
                    r_fill_cnt  <= crop_count(w_line, i_num_records);
                    case (r_req)
                        REQ_BEGIN_READ, REQ_BEGIN_WRITE, REQ_PREFETCH: begin
                            if (r_req == REQ_BEGIN_WRITE && i_read_only) begin
                                r_res   <= n_res;
                                r_state <= S_EMIT;
                            end else if (w_out_range) begin
                                r_res   <= n_res;
                                r_state <= S_EMIT;
                            end else begin
                                r_stamp <= r_stamp + 1'b1;
                                r_state <= S_SCAN;
                            end
                        end
                        REQ_END_READ, REQ_END_WRITE: begin
                            if (r_req == REQ_END_WRITE && i_read_only) begin
                                r_res   <= n_res;
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        REQ_FLUSH: begin
                            if (i_dirty_vec == '0) begin
                                r_res   <= n_res;
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_FLUSH;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (w_tag_eq) begin
                        r_hit   <= 1'b1;
                        r_state <= S_COMMIT;
                    end else begin
                        if (w_older_free) begin
                            r_vic_found <= 1'b1;
                            r_vic_idx   <= r_idx;
                            r_vic_stamp <= i_entry.stamp;
                            r_vic_tag   <= i_entry.tag;
                            r_vic_dirty <= i_entry.dirty;
                        end
                        if (r_idx == LAST_IDX) begin
                            r_state <= S_COMMIT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_COMMIT: begin
                    r_res   <= n_res;
                    r_state <= S_EMIT;
                end
                S_FLUSH: begin
                    if (i_entry.dirty) begin
                        r_res   <= n_res;
                        r_state <= S_EMIT;
                    end else if (r_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EMIT: begin
                    // hold the word until the output register has room
                    if (i_out_ready) begin
                        if (r_res.last || r_req != REQ_FLUSH || r_idx == LAST_IDX) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_FLUSH;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_out_ready)
        else $error("result pushed without room in output register");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_wr.en)
        else $error("line store written while idle");

    a_stamp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_stamp != $past(r_stamp)) |->
            (r_stamp == $past(r_stamp) + 1'b1))
        else $error("stamp counter moved by other than one");

    a_flush_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_req == REQ_FLUSH && r_res.last) |-> (i_dirty_vec == '0))
        else $error("flush finished with dirty lines left");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> o_in_stall)
        else $error("second word accepted while busy");

endmodule

`default_nettype wire

[rtl/pinned_lru_line_cache_tags_core.sv]
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_in_word  (req_type, record_index)
// out       output     o_out_valid / i_out_stall  o_out_word (status .. last)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// An accepted request is decoded in S_DECODE. A begin or end then scans one line a cycle,
// stopping on a hit, then commits and emits its result word before the next accept.
// Rejected and out of range requests skip the scan; unknown codes return to idle with no word.
// Flush walks lines up to the last dirty one and emits one word per dirty line.
// Synchronous reset clears every line, the stamp and the config; no clearing pass follows.
// A stalled output holds one word in its register; the sequencer waits for room.

module pinned_lru_line_cache_tags_core
    import plc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire t_in_word          i_in_word,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output t_out_word              o_out_word,
    input  wire logic              i_out_stall,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [NREC_W-1:0] i_cfg_data
);

    logic              r_read_only;
    logic [NREC_W-1:0] r_num_records;

    t_line_entry       w_entry;
    t_line_vec         w_dirty_vec;
    logic [SLOT_W-1:0] w_rd_idx;
    t_line_wr          w_wr;
    logic              w_out_ready;
    logic              w_push;
    t_out_word         w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_only   <= 1'b0;
            r_num_records <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_READ_ONLY:   r_read_only   <= i_cfg_data[0];
                CFG_NUM_RECORDS: r_num_records <= i_cfg_data;
                default: begin
                    r_read_only <= r_read_only;
                end
            endcase
        end
    end

    plc_line_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_idx    (w_rd_idx),
        .o_entry     (w_entry),
        .o_dirty_vec (w_dirty_vec),
        .i_wr        (w_wr)
    );

    plc_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_word     (i_in_word),
        .o_in_stall    (o_in_stall),
        .i_read_only   (r_read_only),
        .i_num_records (r_num_records),
        .i_entry       (w_entry),
        .i_dirty_vec   (w_dirty_vec),
        .o_rd_idx      (w_rd_idx),
        .o_wr          (w_wr),
        .i_out_ready   (w_out_ready),
        .o_push        (w_push),
        .o_res         (w_res)
    );

    plc_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_res),
        .o_ready (w_out_ready),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .i_stall (i_out_stall)
    );

endmodule

`default_nettype wire

[tb/sv/pinned_lru_line_cache_tags_core_tb.sv]
`default_nettype none

module pinned_lru_line_cache_tags_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    t_in_word          in_word = '0;
    logic              in_stall;
    logic              out_valid;
    t_out_word         out_word;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = 1'b0;
    logic [NREC_W-1:0] cfg_data = '0;

    pinned_lru_line_cache_tags_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Tag store mirror
    logic [LINE_W-1:0]  tag_mirror   [CACHE_LINES];
    logic               held_mirror  [CACHE_LINES];
    logic [1:0]         state_mirror [CACHE_LINES];
    logic               dirty_mirror [CACHE_LINES];
    logic [STAMP_W-1:0] stamp_mirror [CACHE_LINES];
    logic [STAMP_W-1:0] access_clock;
    logic               ro_mode;
    logic [NREC_W-1:0]  store_records;

    t_in_word  req_words  [$];
    t_out_word want_words [$];

    logic in_took = 1'b0;
    int   mismatches = 0;
    int   cycle_cnt = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_reqs = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic logic [CNT_W-1:0] span_of(logic [LINE_W-1:0] ln);
        int unsigned first;
        int unsigned total;
        first = ln * LINE_RECORDS;
        total = store_records;
        if (first >= total) begin
            return '0;
        end
        if (total - first < LINE_RECORDS) begin
            return CNT_W'(total - first);
        end
        return CNT_W'(LINE_RECORDS);
    endfunction

    function automatic int slot_holding(logic [LINE_W-1:0] ln);
        for (int i = 0; i < CACHE_LINES; i++) begin
            if (held_mirror[i] && tag_mirror[i] == ln) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic cache_tags_step(t_in_word w);
        t_out_word         r;
        logic [LINE_W-1:0] ln;
        int                hit;
        int                victim;
        int                last_dirty;
        ln = w.record_index[REC_W-1:OFF_W];
        r = '0;
        r.line_offset = w.record_index[OFF_W-1:0];
        r.last = 1'b1;
        case (w.req_type)
            REQ_BEGIN_READ, REQ_BEGIN_WRITE, REQ_PREFETCH: begin
                if (w.req_type == REQ_BEGIN_WRITE && ro_mode) begin
                    r.status = STS_READ_ONLY;
                end else if ({1'b0, w.record_index} >= store_records) begin
                    r.status = STS_RANGE;
                end else begin
                    access_clock = access_clock + 1'b1;
                    hit = slot_holding(ln);
                    if (hit >= 0) begin
                        state_mirror[hit] = LS_INUSE;
                        stamp_mirror[hit] = access_clock;
                        r.status = STS_HIT;
                        r.slot = SLOT_W'(hit);
                    end else begin
                        victim = -1;
                        for (int i = 0; i < CACHE_LINES; i++) begin
                            if (state_mirror[i] == LS_FREE &&
                                (victim < 0 || stamp_mirror[i] < stamp_mirror[victim])) begin
                                victim = i;
                            end
                        end
                        if (victim < 0) begin
                            r.status = STS_NO_FREE;
                        end else begin
                            if (dirty_mirror[victim]) begin
                                r.writeback_valid = 1'b1;
                                r.writeback_line = tag_mirror[victim];
                                r.writeback_count = span_of(tag_mirror[victim]);
                                dirty_mirror[victim] = 1'b0;
                            end
                            tag_mirror[victim] = ln;
                            held_mirror[victim] = 1'b1;
                            stamp_mirror[victim] = access_clock;
                            state_mirror[victim] =
                                (w.req_type == REQ_PREFETCH) ? LS_FETCH : LS_INUSE;
                            r.status = STS_MISS;
                            r.slot = SLOT_W'(victim);
                            r.fill_valid = 1'b1;
                            r.fill_line = ln;
                            r.fill_count = span_of(ln);
                            r.fill_prefetch = (w.req_type == REQ_PREFETCH);
                        end
                    end
                end
                want_words.push_back(r);
            end
            REQ_END_READ, REQ_END_WRITE: begin
                if (w.req_type == REQ_END_WRITE && ro_mode) begin
                    r.status = STS_READ_ONLY;
                end else begin
                    r.status = STS_DONE;
                    hit = slot_holding(ln);
                    if (hit >= 0) begin
                        r.slot = SLOT_W'(hit);
                        state_mirror[hit] = LS_FREE;
                        if (w.req_type == REQ_END_WRITE) begin
                            dirty_mirror[hit] = 1'b1;
                        end
                    end
                end
                want_words.push_back(r);
            end
            REQ_FLUSH: begin
                r.line_offset = '0;
                r.status = STS_DONE;
                last_dirty = -1;
                for (int i = 0; i < CACHE_LINES; i++) begin
                    if (dirty_mirror[i]) begin
                        last_dirty = i;
                    end
                end
                if (last_dirty < 0) begin
                    want_words.push_back(r);
                end else begin
                    for (int i = 0; i < CACHE_LINES; i++) begin
                        if (dirty_mirror[i]) begin
                            r.slot = SLOT_W'(i);
                            r.writeback_valid = 1'b1;
                            r.writeback_line = tag_mirror[i];
                            r.writeback_count = span_of(tag_mirror[i]);
                            r.last = (i == last_dirty);
                            dirty_mirror[i] = 1'b0;
                            want_words.push_back(r);
                        end
                    end
                end
            end
            default: begin
                // unknown request: no word comes back
            end
        endcase
    endtask

    task automatic field_check(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_word(t_out_word got);
        t_out_word want;
        if (want_words.size() == 0) begin
            $error("result word with nothing expected: %p", got);
            mismatches++;
        end else begin
            want = want_words.pop_front();
            field_check("status", want.status, got.status);
            field_check("slot", want.slot, got.slot);
            field_check("line_offset", want.line_offset, got.line_offset);
            field_check("writeback_valid", want.writeback_valid, got.writeback_valid);
            field_check("writeback_line", want.writeback_line, got.writeback_line);
            field_check("writeback_count", want.writeback_count, got.writeback_count);
            field_check("fill_valid", want.fill_valid, got.fill_valid);
            field_check("fill_line", want.fill_line, got.fill_line);
            field_check("fill_count", want.fill_count, got.fill_count);
            field_check("fill_prefetch", want.fill_prefetch, got.fill_prefetch);
            field_check("last", want.last, got.last);
        end
    endtask

    // Request driver: advance only once the current word has been taken
    always @(negedge clk) begin
        if (!in_valid || in_took) begin
            if (req_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_word <= req_words.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result stall: a requested long hold-off wins over random stalling
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        in_took <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall) begin
            cache_tags_step(in_word);
        end
        if (rst_n && out_valid && !out_stall) begin
            compare_word(out_word);
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [NREC_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        if (idx == CFG_READ_ONLY) begin
            ro_mode = val[0];
        end else begin
            store_records = val;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_req(logic [2:0] kind, logic [REC_W-1:0] rec);
        t_in_word w;
        w.req_type = kind;
        w.record_index = rec;
        req_words.push_back(w);
    endtask

    // Drain: all requests taken, all words back, then let the sequencer go quiet
    task automatic settle();
        while (req_words.size() != 0 || in_valid) begin
            @(posedge clk);
        end
        while (want_words.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [REC_W-1:0] pick_record();
        case ($urandom_range(0, 9))
            0: return REC_W'($urandom());
            1: return {REC_W{1'b1}} - REC_W'($urandom_range(0, 40));
            default: return {LINE_W'($urandom_range(0, 12)), OFF_W'($urandom())};
        endcase
    endfunction

    // Mostly begin/end pairs over a small set of lines, closed in random order,
    // with flushes, stray requests and unknown codes mixed in
    task automatic add_random(int n);
        t_in_word w;
        t_in_word pins [$];
        int       made;
        int       pick;
        int       k;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                w.record_index = pick_record();
                case ($urandom_range(0, 2))
                    0: w.req_type = REQ_BEGIN_READ;
                    1: w.req_type = REQ_BEGIN_WRITE;
                    default: w.req_type = REQ_PREFETCH;
                endcase
                req_words.push_back(w);
                made++;
                w.req_type = (w.req_type == REQ_BEGIN_WRITE) ? REQ_END_WRITE : REQ_END_READ;
                pins.push_back(w);
            end else if (pick < 85) begin
                if (pins.size() != 0) begin
                    k = $urandom_range(0, pins.size() - 1);
                    req_words.push_back(pins[k]);
                    pins.delete(k);
                    made++;
                end
            end else if (pick < 90) begin
                push_req(REQ_FLUSH, REC_W'($urandom()));
                made++;
            end else if (pick < 98) begin
                push_req(3'($urandom_range(0, 5)), REC_W'($urandom()));
                made++;
            end else begin
                push_req(3'($urandom_range(6, 7)), REC_W'($urandom()));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < CACHE_LINES; i++) begin
            tag_mirror[i] = '0;
            held_mirror[i] = 1'b0;
            state_mirror[i] = LS_FREE;
            dirty_mirror[i] = 1'b0;
            stamp_mirror[i] = '0;
        end
        access_clock = '0;
        ro_mode = 1'b0;
        store_records = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_READ_ONLY, '0);
        write_reg(CFG_NUM_RECORDS, NREC_W'(1 << 24));

        // fill every line, hit, unpin, prefetch, run out of free lines, flush
        push_req(REQ_BEGIN_READ, 24'h000000);
        push_req(REQ_BEGIN_READ, 24'hFFFFFF);
        push_req(REQ_BEGIN_READ, 24'h000005);
        push_req(REQ_END_WRITE, 24'h000000);
        push_req(REQ_END_READ, 24'hFFFFFF);
        push_req(REQ_END_READ, 24'h123456);
        push_req(REQ_PREFETCH, 24'h000100);
        push_req(REQ_PREFETCH, 24'h000100);
        push_req(REQ_PREFETCH, 24'h000200);
        push_req(REQ_BEGIN_READ, 24'h000205);
        push_req(REQ_BEGIN_WRITE, 24'h000300);
        push_req(REQ_BEGIN_WRITE, 24'h000400);
        push_req(REQ_BEGIN_WRITE, 24'h000500);
        push_req(REQ_BEGIN_WRITE, 24'h000600);
        push_req(REQ_BEGIN_READ, 24'h000700);
        push_req(REQ_BEGIN_READ, 24'h000800);
        push_req(REQ_BEGIN_READ, 24'h000900);
        push_req(REQ_END_WRITE, 24'h000300);
        push_req(REQ_END_WRITE, 24'h000400);
        push_req(REQ_FLUSH, 24'h000000);
        push_req(REQ_FLUSH, 24'hFFFFFF);
        push_req(3'd6, 24'hFFFFFF);
        push_req(3'd7, 24'h000000);
        settle();

        // shrink the store: write-back past its end, cropped fill, range checks
        write_reg(CFG_NUM_RECORDS, NREC_W'(100));
        push_req(REQ_END_WRITE, 24'h000500);
        push_req(REQ_FLUSH, 24'h000000);
        push_req(REQ_BEGIN_READ, 24'h000063);
        push_req(REQ_BEGIN_READ, 24'h000064);
        settle();

        write_reg(CFG_READ_ONLY, NREC_W'(1));
        push_req(REQ_BEGIN_WRITE, 24'h000010);
        push_req(REQ_END_WRITE, 24'h000010);
        settle();

        write_reg(CFG_READ_ONLY, '0);
        write_reg(CFG_NUM_RECORDS, '0);
        push_req(REQ_PREFETCH, 24'h000000);
        push_req(REQ_END_READ, 24'h000010);
        settle();

        // no idling; hold the results off long enough to back up the input
        write_reg(CFG_NUM_RECORDS, NREC_W'(1 << 24));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_reqs++;
        add_random(22);
        settle();

        write_reg(CFG_NUM_RECORDS, NREC_W'(200));
        send_idle_pct = 83;
        recv_stall_pct = 0;
        add_random(22);
        settle();

        write_reg(CFG_NUM_RECORDS, NREC_W'($urandom_range(1, 250)));
        write_reg(CFG_READ_ONLY, NREC_W'($urandom_range(0, 3) == 0));
        send_idle_pct = 0;
        recv_stall_pct = 83;
        add_random(22);
        settle();

        write_reg(CFG_READ_ONLY, '0);
        write_reg(CFG_NUM_RECORDS, NREC_W'(24'hFFFFFF));
        send_idle_pct = 6;
        recv_stall_pct = 6;
        add_random(22);
        settle();

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/plc_pkg.sv
rtl/plc_line_store.sv
rtl/plc_out_reg.sv
rtl/plc_seq.sv
rtl/pinned_lru_line_cache_tags_core.sv
tb/sv/pinned_lru_line_cache_tags_core_tb.sv
